// ----- hw/rtl/sfap_pkg.sv -----
// Shared types, codes and the control program for the sprite frame animation player.
// Depends on nothing; the top level imports it.
package sfap_pkg;

    localparam int unsigned MAX_FRAMES_DEF = 256;
    localparam int unsigned FC_LIMIT       = 511;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned UPC_W          = 4;

    // Request codes.
    localparam logic [1:0] REQ_PLAY = 2'd0;
    localparam logic [1:0] REQ_STOP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = CFG_IDX_W'(1);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic        loop_mode;
        logic        play_reverse;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_index;
        logic       is_playing;
        logic       frame_advanced;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_SIMPLE,
        OP_LOAD_TPF,
        OP_DIV,
        OP_LOAD_FR,
        OP_STEP_IDX,
        OP_LOAD_MOD,
        OP_WRAP,
        OP_FINISH,
        OP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_NO_TICK,
        C_DIV_MORE,
        C_NO_FRAMES,
        C_NO_WRAP,
        C_OUT_FREE
    } t_ucond;

    typedef struct packed {
        t_uop              op;
        t_ucond            cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    // Program steps.
    localparam logic [UPC_W-1:0] S_IDLE     = UPC_W'(0);
    localparam logic [UPC_W-1:0] S_SIMPLE   = UPC_W'(1);
    localparam logic [UPC_W-1:0] S_LOAD_TPF = UPC_W'(2);
    localparam logic [UPC_W-1:0] S_DIV_TPF  = UPC_W'(3);
    localparam logic [UPC_W-1:0] S_LOAD_FR  = UPC_W'(4);
    localparam logic [UPC_W-1:0] S_DIV_FR   = UPC_W'(5);
    localparam logic [UPC_W-1:0] S_CHK_FR   = UPC_W'(6);
    localparam logic [UPC_W-1:0] S_STEP_IDX = UPC_W'(7);
    localparam logic [UPC_W-1:0] S_CHK_WRAP = UPC_W'(8);
    localparam logic [UPC_W-1:0] S_LOAD_MOD = UPC_W'(9);
    localparam logic [UPC_W-1:0] S_DIV_MOD  = UPC_W'(10);
    localparam logic [UPC_W-1:0] S_WRAP     = UPC_W'(11);
    localparam logic [UPC_W-1:0] S_FINISH   = UPC_W'(12);
    localparam logic [UPC_W-1:0] S_EMIT     = UPC_W'(13);
    localparam logic [UPC_W-1:0] S_EMIT_RTY = UPC_W'(14);

    // Control store: a taken condition jumps to target, else the next step follows.
    function automatic t_uword urom(input logic [UPC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_IDLE:     w = '{OP_ACCEPT,   C_NO_INPUT,  S_IDLE};
            S_SIMPLE:   w = '{OP_SIMPLE,   C_NO_TICK,   S_EMIT};
            S_LOAD_TPF: w = '{OP_LOAD_TPF, C_NEXT,      S_IDLE};
            S_DIV_TPF:  w = '{OP_DIV,      C_DIV_MORE,  S_DIV_TPF};
            S_LOAD_FR:  w = '{OP_LOAD_FR,  C_NEXT,      S_IDLE};
            S_DIV_FR:   w = '{OP_DIV,      C_DIV_MORE,  S_DIV_FR};
            S_CHK_FR:   w = '{OP_NOP,      C_NO_FRAMES, S_EMIT};
            S_STEP_IDX: w = '{OP_STEP_IDX, C_NEXT,      S_IDLE};
            S_CHK_WRAP: w = '{OP_NOP,      C_NO_WRAP,   S_FINISH};
            S_LOAD_MOD: w = '{OP_LOAD_MOD, C_NEXT,      S_IDLE};
            S_DIV_MOD:  w = '{OP_DIV,      C_DIV_MORE,  S_DIV_MOD};
            S_WRAP:     w = '{OP_WRAP,     C_ALWAYS,    S_EMIT};
            S_FINISH:   w = '{OP_FINISH,   C_NEXT,      S_IDLE};
            S_EMIT:     w = '{OP_EMIT,     C_OUT_FREE,  S_IDLE};
            S_EMIT_RTY: w = '{OP_NOP,      C_ALWAYS,    S_EMIT};
            default:    w = '{OP_NOP,      C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/sprite_frame_animation_player.sv -----
// Sprite frame animation player: a microcoded sequencer around a shared bit-serial divider.
// Depends on sfap_pkg for item types, request codes and the control program.
//
// Usage
// The block takes one request item at a time on the input channel (i_in_valid /
// o_in_ready) and returns exactly one result item per request on the output
// channel (o_out_valid / i_out_ready). A play request latches the time and the
// loop and reverse flags, a stop request halts playback, and a tick advances the
// frame index by the whole frames that have passed since the start time.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the frame count
// (index 0) and the whole duration in milliseconds (index 1); it is always ready
// and should only be written while no request is in flight.
// Play, stop, unused codes and ticks while stopped or before the start time go
// straight to the result item. Other ticks run the single shared restoring divider,
// which retires one quotient bit per cycle: 16 bits for the time per frame, 32 for
// the frames passed and, when a looping index wraps, 32 more for the remainder.
// The next request is accepted the cycle after a result item is loaded into the
// output register, so a stalled receiver holds only that one item; the sequencer
// waits for the register to drain before loading the next result.
// Synchronous active-low reset clears the playback state, sets the frame count to
// one and the duration to zero, and returns the sequencer to its idle step.
module sprite_frame_animation_player
    import sfap_pkg::*;
#(
    parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // The frame count register is 9 bits wide, so the usable count never exceeds 511.
    localparam int unsigned MAX_EFF = (MAX_FRAMES < FC_LIMIT) ? MAX_FRAMES : FC_LIMIT;
    localparam int unsigned CNT_W   = $clog2(MAX_EFF + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_EFF);

    // Configuration registers.
    logic [8:0]  r_frame_count;
    logic [15:0] r_duration;

    // Playback state.
    logic [31:0]      r_start;
    logic [IDX_W-1:0] r_cur;
    logic             r_playing;
    logic             r_loop;
    logic             r_rev;

    // Sequencer and datapath.
    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    logic [1:0]       r_req;
    logic [31:0]      r_now;
    logic             r_lp_in;
    logic             r_rv_in;
    logic [31:0]      r_acc;
    logic [15:0]      r_rem;
    logic [15:0]      r_dvs;
    logic [4:0]       r_cnt;
    logic [32:0]      r_idx;
    logic             r_adv;
    logic             r_out_valid;
    t_out_item        r_out;

    t_uword           w_uw;
    logic             w_accept;
    logic             w_out_free;
    logic [CNT_W-1:0] w_n;
    logic [31:0]      w_dt;
    logic [16:0]      w_trial;
    logic             w_qbit;
    logic [15:0]      w_tpf;
    logic             w_in_range;
    logic             w_cond;
    logic [IDX_W-1:0] w_wrap_idx;
    logic [IDX_W-1:0] w_fin_idx;
    logic             w_fin_stop;

    assign w_uw       = urom(r_pc);
    assign o_in_ready = (r_pc == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Frame count saturated into [1, MAX_EFF].
    always_comb begin
        if (r_frame_count == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_frame_count) > MAX_EFF) begin
            w_n = CNT_W'(MAX_EFF);
        end else begin
            w_n = CNT_W'(r_frame_count);
        end
    end

    // Elapsed time; bit 31 set means the tick lies before the start time.
    assign w_dt = r_now - r_start;

    // One restoring division step: the remainder always stays below the divisor.
    assign w_trial = {r_rem, r_acc[31]};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});

    assign w_tpf = (r_acc[15:0] == '0) ? 16'd1 : r_acc[15:0];

    assign w_in_range = !r_idx[32] && (r_idx[31:0] < 32'(w_n));

    // A negative index wraps upward: a nonzero remainder r maps to n - r.
    always_comb begin
        if (r_idx[32] && (r_rem[CNT_W-1:0] != '0)) begin
            w_wrap_idx = IDX_W'(w_n - r_rem[CNT_W-1:0]);
        end else begin
            w_wrap_idx = IDX_W'(r_rem[CNT_W-1:0]);
        end
    end

    // Without looping the index clamps at the ends and playback stops there.
    always_comb begin
        w_fin_stop = 1'b0;
        if (w_in_range) begin
            w_fin_idx = IDX_W'(r_idx[31:0]);
        end else if (r_idx[32]) begin
            w_fin_idx  = '0;
            w_fin_stop = 1'b1;
        end else begin
            w_fin_idx  = IDX_W'(w_n - CNT_W'(1));
            w_fin_stop = 1'b1;
        end
    end

    always_comb begin
        case (w_uw.cond)
            C_NEXT:      w_cond = 1'b0;
            C_ALWAYS:    w_cond = 1'b1;
            C_NO_INPUT:  w_cond = !w_accept;
            C_NO_TICK:   w_cond = (r_req != REQ_TICK) || !r_playing || w_dt[31];
            C_DIV_MORE:  w_cond = (r_cnt != '0);
            C_NO_FRAMES: w_cond = (r_acc == '0);
            C_NO_WRAP:   w_cond = !r_loop || w_in_range;
            C_OUT_FREE:  w_cond = w_out_free;
            default:     w_cond = 1'b1;
        endcase
    end

    assign n_pc = w_cond ? w_uw.target : r_pc + UPC_W'(1);

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_frame_count <= 9'd1;
            r_duration    <= '0;
            r_start       <= '0;
            r_cur         <= '0;
            r_playing     <= 1'b0;
            r_loop        <= 1'b0;
            r_rev         <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[8:0];
                    CFG_DURATION:    r_duration    <= i_cfg_data;
                    default:         ;
                endcase
            end

            // A new result loads only into a free register, so loading wins over draining.
            if ((w_uw.op == OP_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_uw.op)
                OP_SIMPLE: begin
                    if (r_req == REQ_PLAY) begin
                        if ((w_n != CNT_W'(1)) && (r_duration != '0)) begin
                            r_playing <= 1'b1;
                            r_loop    <= r_lp_in;
                            r_rev     <= r_rv_in;
                            r_start   <= r_now;
                        end
                    end else if (r_req == REQ_STOP) begin
                        r_playing <= 1'b0;
                    end
                end
                OP_STEP_IDX: begin
                    // start + frames * tpf equals now minus the division remainder.
                    r_start <= r_now - 32'(r_rem);
                end
                OP_WRAP: begin
                    r_cur <= w_wrap_idx;
                end
                OP_FINISH: begin
                    r_cur <= w_fin_idx;
                    if (w_fin_stop) begin
                        r_playing <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            OP_ACCEPT: begin
                if (w_accept) begin
                    r_req   <= i_in_item.req_type;
                    r_now   <= i_in_item.now_ms;
                    r_lp_in <= i_in_item.loop_mode;
                    r_rv_in <= i_in_item.play_reverse;
                    r_adv   <= 1'b0;
                end
            end
            OP_LOAD_TPF: begin
                r_acc <= {r_duration, 16'd0};
                r_rem <= '0;
                r_dvs <= 16'(w_n);
                r_cnt <= 5'd15;
            end
            OP_DIV: begin
                r_acc <= {r_acc[30:0], w_qbit};
                r_rem <= w_qbit ? 16'(w_trial - {1'b0, r_dvs}) : w_trial[15:0];
                r_cnt <= r_cnt - 5'd1;
            end
            OP_LOAD_FR: begin
                r_acc <= w_dt;
                r_rem <= '0;
                r_dvs <= w_tpf;
                r_cnt <= 5'd31;
            end
            OP_STEP_IDX: begin
                if (r_rev) begin
                    r_idx <= {1'b0, 32'(r_cur)} - {1'b0, r_acc};
                end else begin
                    r_idx <= {1'b0, 32'(r_cur)} + {1'b0, r_acc};
                end
            end
            OP_LOAD_MOD: begin
                r_acc <= r_idx[32] ? 32'(-r_idx) : r_idx[31:0];
                r_rem <= '0;
                r_dvs <= 16'(w_n);
                r_cnt <= 5'd31;
            end
            OP_WRAP: begin
                r_adv <= (w_wrap_idx != r_cur);
            end
            OP_FINISH: begin
                r_adv <= (w_fin_idx != r_cur);
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    r_out.frame_index    <= 8'(r_cur);
                    r_out.is_playing     <= r_playing;
                    r_out.frame_advanced <= r_adv;
                end
            end
            default: ;
        endcase
    end

    // The sequencer leaves its idle step as soon as an item is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input still ready after an item was accepted");

    // The divider never runs against a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == OP_DIV) |-> (r_dvs != '0))
        else $error("division step with a zero divisor");

    // Only a tick can report a frame change.
    a_adv_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_uw.op == OP_EMIT) && (r_req != REQ_TICK)) |-> !r_adv)
        else $error("frame change reported for a request that is not a tick");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for sprite_frame_animation_player.
// Depends on sfap_pkg for the item types, request codes and register indexes.
// Drives request items under random idling and checks each result item against a predictor.
`timescale 1ns / 100ps

module testbench;
    import sfap_pkg::*;

    // Request code that the block leaves unused, and a register index that it ignores.
    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = CFG_IDX_W'(3);

    localparam int unsigned FRAMES_MAX   = MAX_FRAMES_DEF;
    localparam int          ITEM_TARGET  = 1400;
    // The slowest item is a looping wrap, with three divider runs, plus sender gaps and
    // receiver stalls; this limit is many times that.
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 128;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    sprite_frame_animation_player uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor copy of the registers and of the playback state, all at reset values.
    logic [8:0]  fc_reg       = 9'd1;
    logic [15:0] dur_reg      = 16'd0;
    logic [31:0] anim_start   = 32'd0;
    logic [7:0]  anim_frame   = 8'd0;
    bit          anim_playing = 1'b0;
    bit          anim_looping = 1'b0;
    bit          anim_reverse = 1'b0;

    t_out_item expected_frames[$];
    int        mismatches = 0;

    // Sender state: remaining items in the current burst and whether valid is raised.
    int burst_left = 0;
    bit in_busy    = 1'b0;

    // The frame count register saturated to the range the block supports.
    function automatic logic [31:0] frames_in_anim();
        if (fc_reg == 9'd0)
            return 32'd1;
        if (fc_reg > FRAMES_MAX)
            return FRAMES_MAX;
        return 32'(fc_reg);
    endfunction

    // Milliseconds per frame; a zero quotient is held at 1 ms.
    function automatic logic [31:0] frame_period();
        logic [31:0] tpf;
        tpf = 32'(dur_reg) / frames_in_anim();
        return (tpf == 32'd0) ? 32'd1 : tpf;
    endfunction

    // Applies one request to the playback state and returns the result it produces.
    function automatic t_out_item advance_animation(input t_in_item it);
        logic [31:0] n;
        logic [31:0] dt;
        logic [31:0] tpf;
        logic [31:0] passed;
        longint      idx;
        longint      sn;
        logic [7:0]  prev;
        bit          moved;
        t_out_item   res;
        n     = frames_in_anim();
        sn    = longint'(n);
        prev  = anim_frame;
        moved = 1'b0;
        case (it.req_type)
            REQ_PLAY: begin
                // Playback only starts with more than one frame and a nonzero duration.
                if (n != 32'd1 && dur_reg != 16'd0) begin
                    anim_playing = 1'b1;
                    anim_looping = it.loop_mode;
                    anim_reverse = it.play_reverse;
                    anim_start   = it.now_ms;
                end
            end
            REQ_STOP: anim_playing = 1'b0;
            REQ_TICK: begin
                dt = it.now_ms - anim_start;
                // A time before the start reads as negative and passes no frames.
                if (anim_playing && !dt[31]) begin
                    tpf    = frame_period();
                    passed = dt / tpf;
                    if (passed != 32'd0) begin
                        anim_start = anim_start + passed * tpf;
                        idx = anim_reverse ? longint'(anim_frame) - longint'(passed)
                                           : longint'(anim_frame) + longint'(passed);
                        if (anim_looping) begin
                            if (idx < 0 || idx >= sn) begin
                                idx = idx % sn;
                                if (idx < 0)
                                    idx = idx + sn;
                            end
                        end else if (idx < 0) begin
                            idx          = 0;
                            anim_playing = 1'b0;
                        end else if (idx >= sn) begin
                            idx          = sn - 1;
                            anim_playing = 1'b0;
                        end
                        anim_frame = idx[7:0];
                        moved      = (anim_frame != prev);
                    end
                end
            end
            default: ;
        endcase
        res.frame_index    = anim_frame;
        res.is_playing     = anim_playing;
        res.frame_advanced = moved;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sends one request item. The sender runs in bursts; between bursts valid may drop
    // for a random gap. The expectation is queued at the edge that accepts the item.
    task automatic send_req(input logic [1:0] req, input logic [31:0] now, input bit lp,
                            input bit rv);
        int       gap;
        t_in_item it;
        it = '{req_type: req, now_ms: now, loop_mode: lp, play_reverse: rv};
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
            if (gap > 0) begin
                if (in_busy) begin
                    i_in_valid <= 1'b0;
                    in_busy = 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        in_busy = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_frames.push_back(advance_animation(it));
    endtask

    // Holds the sender back until every expected result item has come out.
    task automatic wait_drained();
        if (in_busy) begin
            i_in_valid <= 1'b0;
            in_busy = 1'b0;
        end
        burst_left = 0;
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_COUNT: fc_reg = data[8:0];
            CFG_DURATION:    dur_reg = data;
            default: ;
        endcase
    endtask

    // Register writes happen only with the block idle, so drain first.
    task automatic set_config(input bit wr_fc, input logic [15:0] fc_data, input bit wr_dur,
                              input logic [15:0] dur_data, input bit wr_spare);
        wait_drained();
        if (wr_fc)
            cfg_put(CFG_FRAME_COUNT, fc_data);
        if (wr_dur)
            cfg_put(CFG_DURATION, dur_data);
        if (wr_spare)
            cfg_put(CFG_SPARE, CFG_DATA_W'($urandom()));
        i_cfg_valid <= 1'b0;
    endtask

    // Forward play without looping: a tick short of one frame, one frame, then a jump
    // past the last frame that clamps and stops. Also the unused request code and a stop
    // after playback has ended.
    task automatic test_play_and_clamp();
        set_config(1'b1, 16'd4, 1'b1, 16'd400, 1'b0);
        send_req(REQ_PLAY, 32'd1000, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'd1050, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'd1100, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'd1350, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'd2000, 1'b1, 1'b1);
        send_req(REQ_UNUSED, 32'hA5A5_5A5A, 1'b1, 1'b1);
        send_req(REQ_STOP, 32'd0, 1'b0, 1'b0);
    endtask

    // Reverse looping play started just before the millisecond counter wraps, a tick
    // earlier than the start time, and a backward step that needs the negative
    // remainder corrected.
    task automatic test_reverse_wrap();
        send_req(REQ_PLAY, 32'hFFFF_FFF0, 1'b1, 1'b1);
        send_req(REQ_TICK, 32'h0000_0050, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'h0000_0150, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'h0000_0100, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'h0000_0380, 1'b0, 1'b0);
        send_req(REQ_STOP, 32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    // A frame count of zero acts as one, a zero duration blocks play, a count above
    // the maximum saturates, a time per frame below 1 ms is held at 1 ms, and the
    // largest register values clamp a reverse play at frame zero.
    task automatic test_degenerate_config();
        set_config(1'b1, 16'd0, 1'b1, 16'd100, 1'b0);
        send_req(REQ_PLAY, 32'd500, 1'b1, 1'b0);
        send_req(REQ_TICK, 32'd900, 1'b0, 1'b0);
        set_config(1'b1, 16'd8, 1'b1, 16'd0, 1'b1);
        send_req(REQ_PLAY, 32'd500, 1'b0, 1'b0);
        set_config(1'b1, 16'd300, 1'b1, 16'd5, 1'b0);
        send_req(REQ_PLAY, 32'd0, 1'b1, 1'b0);
        send_req(REQ_TICK, 32'd1000, 1'b0, 1'b0);
        set_config(1'b1, 16'd511, 1'b1, 16'hFFFF, 1'b0);
        send_req(REQ_PLAY, 32'd100, 1'b0, 1'b1);
        send_req(REQ_TICK, 32'h7FFF_FFFF, 1'b0, 1'b0);
    endtask

    // The frame count shrinks below the stored index between ticks: looping wraps the
    // index, non-looping clamps it to the last frame and stops.
    task automatic test_shrunk_count();
        set_config(1'b1, 16'd200, 1'b1, 16'd2000, 1'b0);
        send_req(REQ_PLAY, 32'd0, 1'b1, 1'b0);
        send_req(REQ_TICK, 32'd1500, 1'b0, 1'b0);
        set_config(1'b1, 16'd10, 1'b0, 16'd0, 1'b0);
        send_req(REQ_TICK, 32'd1700, 1'b0, 1'b0);
        set_config(1'b1, 16'd200, 1'b0, 16'd0, 1'b0);
        send_req(REQ_PLAY, 32'd2000, 1'b0, 1'b0);
        send_req(REQ_TICK, 32'd3500, 1'b0, 1'b0);
        set_config(1'b1, 16'd10, 1'b0, 16'd0, 1'b0);
        send_req(REQ_TICK, 32'd3700, 1'b0, 1'b0);
    endtask

    // Random phases: each picks a setting, then sends mostly plays and ticks that walk
    // a local clock forward by up to three frames a step, mixed with stops, unused codes,
    // ticks at random times and ticks before the start. Every item sent counts toward
    // the target.
    task automatic test_random_traffic();
        int          sent;
        int          burst;
        int          pick;
        logic [31:0] tms;
        logic [31:0] now;
        logic [31:0] tpf;
        logic [8:0]  fc9;
        logic [15:0] fc_data;
        logic [15:0] dur_data;
        logic [1:0]  req;
        bit          lp;
        bit          rv;
        bit          wr_fc;
        bit          wr_dur;
        sent = 0;
        while (sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       fc9 = 9'd0;
                1:       fc9 = 9'd1;
                2:       fc9 = 9'd256;
                3:       fc9 = 9'($urandom_range(257, 511));
                4, 5:    fc9 = 9'($urandom_range(2, 256));
                default: fc9 = 9'($urandom_range(2, 12));
            endcase
            fc_data = 16'(fc9);
            if ($urandom_range(0, 7) == 0)
                fc_data[15:9] = 7'($urandom_range(0, 127));
            case ($urandom_range(0, 9))
                0:       dur_data = 16'd0;
                1:       dur_data = 16'hFFFF;
                2:       dur_data = 16'($urandom_range(1, 300));
                3, 4:    dur_data = 16'($urandom_range(0, 65535));
                default: dur_data = 16'($urandom_range(1, 2000));
            endcase
            // Sometimes only one register changes, so playback carries across settings.
            pick   = $urandom_range(0, 9);
            wr_fc  = (pick != 0);
            wr_dur = (pick != 1);
            set_config(wr_fc, fc_data, wr_dur, dur_data, $urandom_range(0, 15) == 0);
            tms   = $urandom();
            burst = $urandom_range(20, 60);
            repeat (burst) begin
                tpf  = frame_period();
                pick = $urandom_range(0, 99);
                lp   = $urandom_range(0, 1);
                rv   = $urandom_range(0, 1);
                if (!anim_playing && pick < 50)
                    pick = 0;
                if (pick < 8) begin
                    req = REQ_PLAY;
                    now = tms;
                end else if (pick < 12) begin
                    req = REQ_STOP;
                    now = $urandom();
                end else if (pick < 15) begin
                    req = REQ_UNUSED;
                    now = $urandom();
                end else if (pick < 20) begin
                    req = REQ_TICK;
                    now = $urandom();
                end else if (pick < 24) begin
                    req = REQ_TICK;
                    now = anim_start - $urandom_range(1, 1000);
                end else if (pick < 30) begin
                    req = REQ_TICK;
                    tms = tms + $urandom_range(0, 2 * tpf * frames_in_anim());
                    now = tms;
                end else begin
                    req = REQ_TICK;
                    tms = tms + $urandom_range(0, 3 * tpf);
                    now = tms;
                end
                sent++;
                send_req(req, now, lp, rv);
                // Now and then the sender holds off until the block has emptied out.
                if ($urandom_range(0, 63) == 0)
                    wait_drained();
            end
        end
    endtask

    // Receiver: alternating runs of ready and stall of random length, with an
    // occasional long run of no stalls at all.
    int rx_phase_left = 0;
    bit rx_stalled    = 1'b1;

    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_stalled    = !rx_stalled;
            rx_phase_left = rx_stalled ? $urandom_range(1, 12)
                          : (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40));
        end
        rx_phase_left--;
        i_out_ready <= !rx_stalled;
    end

    // Each accepted result item is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("result item with none expected", longint'(o_out_item), 0);
            end else begin
                want = expected_frames.pop_front();
                if (o_out_item.frame_index !== want.frame_index)
                    report_mismatch("frame_index", o_out_item.frame_index, want.frame_index);
                if (o_out_item.is_playing !== want.is_playing)
                    report_mismatch("is_playing", o_out_item.is_playing, want.is_playing);
                if (o_out_item.frame_advanced !== want.frame_advanced)
                    report_mismatch("frame_advanced", o_out_item.frame_advanced,
                                    want.frame_advanced);
            end
        end
    end

    // Watchdog: ends the run once no handshake of any kind has happened for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_play_and_clamp();
        test_reverse_wrap();
        test_degenerate_config();
        test_shrunk_count();
        test_random_traffic();
        wait_drained();
        // Any result item that shows up late is caught by the checker here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sfap_pkg.sv
hw/rtl/sprite_frame_animation_player.sv
dv/testbench.sv
